>>> rtl/les_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// les_pkg: shared types and constants for the LED effect sequencer
// Field widths, effect and command codes, controller states and the
// structs that run between the controller and the serial divider.
// ----------------------------------------------------------------------------
package les_pkg;

  localparam int DUTY_BITS  = 8;               // PWM resolution of the LED channel
  localparam int DUTY_OUT_W = 8;
  localparam int MODE_W     = 3;
  localparam int EFFECT_W   = 3;
  localparam int TIME_W     = 16;
  localparam int TOTAL_W    = 24;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  typedef logic [DUTY_BITS-1:0] level_t;
  localparam level_t MAX_DUTY = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_ON       = 3'd1,
    MODE_OFF      = 3'd2,
    MODE_FADE_IN  = 3'd3,
    MODE_FADE_OUT = 3'd4,
    MODE_BREATHE  = 3'd5,
    MODE_BLINK    = 3'd6,
    MODE_TIMED    = 3'd7
  } mode_t;

  typedef enum logic [EFFECT_W-1:0] {
    EFF_STATIC   = 3'd0,
    EFF_FADE_IN  = 3'd1,
    EFF_FADE_OUT = 3'd2,
    EFF_BREATHE  = 3'd3,
    EFF_BLINK    = 3'd4,
    EFF_TIMED    = 3'd5
  } effect_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TIMED,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  dividend;
    level_t             divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [TIME_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                  load;
    logic [DUTY_OUT_W-1:0] duty;
    logic [EFFECT_W-1:0]   effect;
  } result_t;

  // Level as driven on the port: zero-extended, then cut to the port width
  function automatic logic [DUTY_OUT_W-1:0] duty_out(level_t lvl);
    logic [DUTY_BITS+DUTY_OUT_W-1:0] ext;
    ext = (DUTY_BITS+DUTY_OUT_W)'(lvl);
    return ext[DUTY_OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/les_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// les_in_if: command / tick channel
// Valid-ready channel carrying one tick or effect command per transaction.
// ----------------------------------------------------------------------------
interface les_in_if;
  logic                         valid;
  logic                         ready;
  logic [les_pkg::MODE_W-1:0]   mode;
  logic [les_pkg::TIME_W-1:0]   fade_or_on_ms;
  logic [les_pkg::TIME_W-1:0]   off_ms;
  logic [les_pkg::TOTAL_W-1:0]  total_ms;

  modport source (output valid, mode, fade_or_on_ms, off_ms, total_ms, input ready);
  modport sink   (input valid, mode, fade_or_on_ms, off_ms, total_ms, output ready);
endinterface
`default_nettype wire

>>> rtl/les_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// les_out_if: duty / effect result channel
// Valid-ready channel carrying the LED state after each transaction.
// ----------------------------------------------------------------------------
interface les_out_if;
  logic                            valid;
  logic                            ready;
  logic [les_pkg::DUTY_OUT_W-1:0]  duty;
  logic [les_pkg::EFFECT_W-1:0]    effect;

  modport source (output valid, duty, effect, input ready);
  modport sink   (input valid, duty, effect, output ready);
endinterface
`default_nettype wire

>>> rtl/les_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// les_div: bit-serial restoring divider
// Fade time / remaining counts, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module les_div (
  input  logic              clk,
  input  logic              rst,
  input  les_pkg::div_req_t req,
  output les_pkg::div_rsp_t rsp
);
  import les_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    shreg;   // dividend out at the top, quotient in at the bottom
  level_t               dvsr;
  level_t               rem;
  level_t               rem_next;
  logic [DUTY_BITS:0]   trial;
  logic [DUTY_BITS:0]   diff;
  logic                 ge;

  always_comb begin
    trial    = {rem, shreg[TIME_W-1]};
    diff     = trial - {1'b0, dvsr};
    ge       = (trial >= {1'b0, dvsr});
    rem_next = ge ? diff[DUTY_BITS-1:0] : trial[DUTY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.dividend;
      dvsr  <= req.divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[TIME_W-2:0], ge};
      rem   <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shreg;

endmodule
`default_nettype wire

>>> rtl/les_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// les_ctrl: effect state machine
// Holds the effect state, decodes ticks and commands, starts the divider
// for fade waits and runs the timed-blink phase bookkeeping.
// ----------------------------------------------------------------------------
module les_ctrl (
  input  logic              clk,
  input  logic              rst,
  les_in_if.sink            cmd,
  output les_pkg::div_req_t div_req,
  input  les_pkg::div_rsp_t div_rsp,
  output les_pkg::result_t  result,
  input  logic              out_free
);
  import les_pkg::*;

  state_t              state, state_next;
  level_t              duty, duty_next;
  effect_t             eff, eff_next;
  logic                phase, phase_next;
  logic [TIME_W-1:0]   step_wait, step_wait_next;
  logic [TIME_W-1:0]   wait_cnt, wait_cnt_next;
  logic [TOTAL_W-1:0]  elapsed, elapsed_next;
  logic [TIME_W-1:0]   time_a, time_a_next;
  logic [TIME_W-1:0]   time_b, time_b_next;
  logic [TOTAL_W-1:0]  time_total, time_total_next;
  logic                pend_up, pend_up_next;      // direction of pending step / blink phase
  logic                pend_min1, pend_min1_next;
  logic [TOTAL_W:0]    rem_t, rem_t_next;          // total - elapsed, top bit is borrow
  logic                accept;
  logic                go_div;
  logic                go_timed;
  logic [TIME_W-1:0]   wait_q;
  logic [TIME_W-1:0]   phase_len;
  mode_t               mode;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign mode      = mode_t'(cmd.mode);

  // Datapath next values and outputs
  always_comb begin
    duty_next       = duty;
    eff_next        = eff;
    phase_next      = phase;
    step_wait_next  = step_wait;
    wait_cnt_next   = wait_cnt;
    elapsed_next    = elapsed;
    time_a_next     = time_a;
    time_b_next     = time_b;
    time_total_next = time_total;
    pend_up_next    = pend_up;
    pend_min1_next  = pend_min1;
    rem_t_next      = rem_t;
    go_div          = 1'b0;
    go_timed        = 1'b0;
    wait_q          = div_rsp.quotient;
    phase_len       = pend_up ? time_a : time_b;
    result.load     = 1'b0;
    result.duty     = duty_out(duty);
    result.effect   = eff;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_TICK: begin
              if (eff != EFF_STATIC) begin
                if (wait_cnt > TIME_W'(1)) begin
                  wait_cnt_next = wait_cnt - 1'b1;
                end else begin
                  case (eff)
                    EFF_FADE_IN: begin
                      if (duty != MAX_DUTY) begin
                        duty_next     = duty + 1'b1;
                        wait_cnt_next = step_wait;
                      end else begin
                        duty_next      = MAX_DUTY;
                        eff_next       = EFF_STATIC;
                        phase_next     = 1'b0;
                        step_wait_next = '0;
                        wait_cnt_next  = '0;
                      end
                    end
                    EFF_FADE_OUT: begin
                      if (duty != '0) begin
                        duty_next     = duty - 1'b1;
                        wait_cnt_next = step_wait;
                      end else begin
                        duty_next      = '0;
                        eff_next       = EFF_STATIC;
                        phase_next     = 1'b0;
                        step_wait_next = '0;
                        wait_cnt_next  = '0;
                      end
                    end
                    EFF_BREATHE: begin
                      if (phase && duty != MAX_DUTY) begin
                        duty_next     = duty + 1'b1;
                        wait_cnt_next = step_wait;
                      end else if (!phase && duty != '0) begin
                        duty_next     = duty - 1'b1;
                        wait_cnt_next = step_wait;
                      end else begin
                        // end of a half: turn round, new wait over the full range
                        pend_up_next   = !phase;
                        pend_min1_next = 1'b1;
                        go_div         = 1'b1;
                      end
                    end
                    EFF_BLINK: begin
                      phase_next    = !phase;
                      duty_next     = phase ? '0 : MAX_DUTY;
                      wait_cnt_next = phase ? time_b : time_a;
                    end
                    EFF_TIMED: begin
                      rem_t_next   = {1'b0, time_total} - {1'b0, elapsed};
                      pend_up_next = !phase;
                      go_timed     = 1'b1;
                    end
                    default: ;
                  endcase
                end
              end
            end
            MODE_ON, MODE_OFF: begin
              duty_next      = (mode == MODE_ON) ? MAX_DUTY : '0;
              eff_next       = EFF_STATIC;
              phase_next     = 1'b0;
              step_wait_next = '0;
              wait_cnt_next  = '0;
            end
            MODE_FADE_IN, MODE_FADE_OUT: begin
              if (eff != ((mode == MODE_FADE_IN) ? EFF_FADE_IN : EFF_FADE_OUT)) begin
                eff_next        = EFF_STATIC;
                phase_next      = 1'b0;
                step_wait_next  = '0;
                wait_cnt_next   = '0;
                time_a_next     = cmd.fade_or_on_ms;
                time_b_next     = '0;
                time_total_next = '0;
                // already at the end value: stays static
                if ((mode == MODE_FADE_IN) ? (duty != MAX_DUTY) : (duty != '0)) begin
                  eff_next       = (mode == MODE_FADE_IN) ? EFF_FADE_IN : EFF_FADE_OUT;
                  pend_up_next   = (mode == MODE_FADE_IN);
                  pend_min1_next = (mode == MODE_FADE_IN);
                  go_div         = 1'b1;
                end
              end
            end
            MODE_BREATHE: begin
              eff_next        = EFF_BREATHE;
              phase_next      = 1'b0;
              step_wait_next  = '0;
              wait_cnt_next   = '0;
              time_a_next     = cmd.fade_or_on_ms;
              time_b_next     = '0;
              time_total_next = '0;
              pend_up_next    = (duty != MAX_DUTY);
              pend_min1_next  = 1'b1;
              go_div          = 1'b1;
            end
            MODE_BLINK: begin
              eff_next        = EFF_BLINK;
              phase_next      = 1'b1;
              duty_next       = MAX_DUTY;
              step_wait_next  = '0;
              wait_cnt_next   = cmd.fade_or_on_ms;
              time_a_next     = cmd.fade_or_on_ms;
              time_b_next     = cmd.off_ms;
              time_total_next = '0;
            end
            MODE_TIMED: begin
              eff_next        = EFF_TIMED;
              phase_next      = 1'b0;
              step_wait_next  = '0;
              wait_cnt_next   = '0;
              time_a_next     = cmd.fade_or_on_ms;
              time_b_next     = cmd.off_ms;
              time_total_next = cmd.total_ms;
              elapsed_next    = '0;
              rem_t_next      = {1'b0, cmd.total_ms};
              pend_up_next    = 1'b1;
              go_timed        = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (pend_min1 && wait_q == '0) begin
            wait_q = TIME_W'(1);
          end
          if (wait_q == '0) begin
            // fade-out wait of zero ends at once
            duty_next      = '0;
            eff_next       = EFF_STATIC;
            phase_next     = 1'b0;
            step_wait_next = '0;
            wait_cnt_next  = '0;
          end else begin
            step_wait_next = wait_q;
            wait_cnt_next  = wait_q;
            phase_next     = pend_up;
            duty_next      = pend_up ? duty + 1'b1 : duty - 1'b1;
          end
        end
      end

      ST_TIMED: begin
        if (rem_t[TOTAL_W] || rem_t == '0) begin
          duty_next      = '0;
          eff_next       = EFF_STATIC;
          phase_next     = 1'b0;
          step_wait_next = '0;
          wait_cnt_next  = '0;
        end else begin
          duty_next  = pend_up ? MAX_DUTY : '0;
          phase_next = pend_up;
          if (TOTAL_W'(phase_len) > rem_t[TOTAL_W-1:0]) begin
            // phase cut short at the total
            wait_cnt_next = rem_t[TIME_W-1:0];
            elapsed_next  = time_total;
          end else begin
            wait_cnt_next = phase_len;
            elapsed_next  = elapsed + TOTAL_W'(phase_len);
          end
        end
      end

      ST_DONE: begin
        result.load = out_free;
      end

      default: ;
    endcase

    div_req.start    = go_div;
    div_req.dividend = time_a_next;
    div_req.divisor  = pend_up_next ? (MAX_DUTY - duty) : duty;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (go_div) begin
            state_next = ST_DIV;
          end else if (go_timed) begin
            state_next = ST_TIMED;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_TIMED: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      duty       <= '0;
      eff        <= EFF_STATIC;
      phase      <= 1'b0;
      step_wait  <= '0;
      wait_cnt   <= '0;
      elapsed    <= '0;
      time_a     <= '0;
      time_b     <= '0;
      time_total <= '0;
      pend_up    <= 1'b0;
      pend_min1  <= 1'b0;
      rem_t      <= '0;
    end else begin
      state      <= state_next;
      duty       <= duty_next;
      eff        <= eff_next;
      phase      <= phase_next;
      step_wait  <= step_wait_next;
      wait_cnt   <= wait_cnt_next;
      elapsed    <= elapsed_next;
      time_a     <= time_a_next;
      time_b     <= time_b_next;
      time_total <= time_total_next;
      pend_up    <= pend_up_next;
      pend_min1  <= pend_min1_next;
      rem_t      <= rem_t_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/led_effect_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_effect_sequencer_top: LED blink / fade / breathe sequencer
// Takes 1 ms ticks and effect commands, answers each with the PWM duty and
// the running effect.
// ----------------------------------------------------------------------------
//  Channel | Dir | Interface  | Payload
//  --------+-----+------------+-----------------------------------------------
//  cmd     | in  | les_in_if  | mode, fade_or_on_ms, off_ms, total_ms
//  res     | out | les_out_if | duty, effect (one transaction per cmd)
//
//  Command paths: on, off, blink, ignored or already finished fades and ticks
//  that need no step wait or timed-blink phase go straight to the result; a
//  timed-blink phase change first does the remaining-time subtract, then the
//  compare and update; a fade or breathe step wait is set by the bit-serial
//  divider, which resolves one quotient bit per cycle of a 16-bit quotient.
//  One transaction is processed at a time; the next cmd is taken once the
//  result has moved into the output register, which may still be waiting on
//  res.ready. Synchronous active-high reset: duty 0, effect static, all
//  timers cleared.
// ----------------------------------------------------------------------------
module led_effect_sequencer_top (
  input  logic      clk,
  input  logic      rst,
  les_in_if.sink    cmd,
  les_out_if.source res
);
  import les_pkg::*;

  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  result;
  logic     out_free;
  logic     out_valid;

  // Step-wait divider: fade time / counts left to go
  les_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Effect state machine and timers
  les_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .result   (result),
    .out_free (out_free)
  );

  // Output register: slot is free when empty or being drained this cycle
  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      res.duty   <= result.duty;
      res.effect <= result.effect;
    end
  end

  assign res.valid = out_valid;

endmodule
`default_nettype wire
